[hdl/cia_pkg.sv]
// ----------------------------------------------------------------------------
// cia_pkg
// shared types, codes and the divider step of the checked integer alu
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int W = 32;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_REM = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic [2:0]     op;
    logic           sg;
    logic           sa;
    logic           sb;
    logic [W-1:0]   rem;
    logic [W-1:0]   quo;
    logic [W-1:0]   dvs;
    logic [W-1:0]   res;
    logic [1:0]     st;
    logic [2*W-1:0] prod;
  } stage_t;

  // one restoring division step: shift in the next dividend bit
  function automatic stage_t div_step(stage_t s);
    logic [W:0] t;
    logic [W:0] diff;
    stage_t     o;
    o      = s;
    t      = {s.rem, s.quo[W-1]};
    diff   = t - {1'b0, s.dvs};
    o.quo  = {s.quo[W-2:0], 1'b0};
    if (t >= {1'b0, s.dvs}) begin
      o.rem    = diff[W-1:0];
      o.quo[0] = 1'b1;
    end else begin
      o.rem = t[W-1:0];
    end
    return o;
  endfunction

endpackage

[hdl/checked_integer_alu.sv]
// ----------------------------------------------------------------------------
// checked_integer_alu
// overflow-checked add, subtract, multiply, divide and remainder
// ----------------------------------------------------------------------------
// usage:
//   requests arrive on the in_ stream: in_tuser carries the operation and the
//   signedness flag, in_tdata the two operands. each request gives exactly one
//   result on the out_ stream: out_tdata is the result, out_tuser the status
//   (ok, overflow, divide by zero). on any failure the result is zero.
// depth: 35 register stages. the depth is set by the divider, which retires
//   one quotient bit per stage over 32 stages, plus an input stage, an operand
//   prep stage and the final sign fix-up / output register. the multiplier sits
//   in the first divider stage and its range check in the second, running
//   alongside.
// throughput: one request per cycle, sustained while the output is not held off.
// stall: the whole pipeline advances together whenever the output register
//   is empty or being taken; while the receiver holds off a valid result,
//   every stage holds and in_tready is low, so nothing is lost or repeated.
// reset: synchronous, active low; clears all stage valid bits, so the
//   pipeline comes up empty and ready.
module checked_integer_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] operand_a, [63:32] operand_b
  input  logic [3:0]  in_tuser,   // [2:0] req_type, [3] is_signed
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_value
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int W = cia_pkg::W;

  // global advance: output register empty or being drained
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // input stage
  logic         in_vld_r;
  logic [2:0]   in_op_r;
  logic         in_sg_r;
  logic [W-1:0] in_a_r;
  logic [W-1:0] in_b_r;

  // operand prep, divider stages and output
  cia_pkg::stage_t st_r   [0:W];
  cia_pkg::stage_t st_nxt [0:W];
  logic            vld_r  [0:W];
  logic [31:0]     res_r, res_nxt;
  logic [1:0]      sts_r, sts_nxt;
  logic            out_vld_r;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = res_r;
  assign out_tuser  = sts_r;

  // operand prep: sign magnitudes, add/sub with checks, early status
  always_comb begin
    logic         sa, sb;
    logic [W:0]   sum, dif;
    cia_pkg::stage_t s;
    sa   = in_a_r[W-1];
    sb   = in_b_r[W-1];
    sum  = {1'b0, in_a_r} + {1'b0, in_b_r};
    dif  = {1'b0, in_a_r} - {1'b0, in_b_r};
    s        = '0;
    s.op     = in_op_r;
    s.sg     = in_sg_r;
    s.sa     = sa;
    s.sb     = sb;
    s.rem    = '0;
    s.quo    = (in_sg_r && sa) ? (~in_a_r + 1'b1) : in_a_r;
    s.dvs    = (in_sg_r && sb) ? (~in_b_r + 1'b1) : in_b_r;
    s.st     = cia_pkg::ST_OK;
    s.res    = '0;
    case (in_op_r)
      cia_pkg::OP_ADD: begin
        s.res = sum[W-1:0];
        if (in_sg_r ? (sa == sb && sum[W-1] != sa) : sum[W]) s.st = cia_pkg::ST_OVF;
      end
      cia_pkg::OP_SUB: begin
        s.res = dif[W-1:0];
        if (in_sg_r ? (sa != sb && dif[W-1] != sa) : dif[W]) s.st = cia_pkg::ST_OVF;
      end
      cia_pkg::OP_MUL: ;
      cia_pkg::OP_DIV, cia_pkg::OP_REM: begin
        if (in_b_r == '0) s.st = cia_pkg::ST_DIV0;
      end
      default: s.st = cia_pkg::ST_OVF;
    endcase
    st_nxt[0] = s;
  end

  // divider stages; multiply rides in stage 1, its check in stage 2
  for (genvar k = 1; k <= W; k++) begin : g_stage
    always_comb begin
      logic            neg;
      logic [W-1:0]    lo, hi, lim;
      cia_pkg::stage_t s;
      s   = cia_pkg::div_step(st_r[k-1]);
      lo  = st_r[k-1].prod[W-1:0];
      hi  = st_r[k-1].prod[2*W-1:W];
      neg = (st_r[k-1].sa != st_r[k-1].sb) && (lo != '0);
      lim = neg ? cia_pkg::HALF : cia_pkg::HALF - 1'b1;
      if (k == 1) begin
        s.prod = {{W{1'b0}}, st_r[k-1].quo} * {{W{1'b0}}, st_r[k-1].dvs};
      end
      if (k == 2 && st_r[k-1].op == cia_pkg::OP_MUL) begin
        if (st_r[k-1].sg) begin
          if (hi != '0 || lo > lim) s.st = cia_pkg::ST_OVF;
          else s.res = neg ? (~lo + 1'b1) : lo;
        end else begin
          if (hi != '0) s.st = cia_pkg::ST_OVF;
          else s.res = lo;
        end
      end
      st_nxt[k] = s;
    end
  end

  // final fix-up: signs of quotient and remainder, signed divide overflow, zero on failure
  always_comb begin
    cia_pkg::stage_t s;
    logic [1:0]      st;
    logic [W-1:0]    r;
    s  = st_r[W];
    st = s.st;
    r  = s.res;
    if (st == cia_pkg::ST_OK) begin
      if (s.op == cia_pkg::OP_DIV) begin
        if (s.sg && s.sa != s.sb) r = ~s.quo + 1'b1;
        else if (s.sg && s.quo > cia_pkg::HALF - 1'b1) st = cia_pkg::ST_OVF;
        else r = s.quo;
      end else if (s.op == cia_pkg::OP_REM) begin
        r = (s.sg && s.sa) ? (~s.rem + 1'b1) : s.rem;
      end
    end
    sts_nxt = st;
    res_nxt = (st == cia_pkg::ST_OK) ? r[31:0] : 32'd0;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      for (int i = 0; i <= W; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      in_vld_r  <= in_tvalid;
      vld_r[0]  <= in_vld_r;
      for (int i = 1; i <= W; i++) vld_r[i] <= vld_r[i-1];
      out_vld_r <= vld_r[W];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      in_op_r <= in_tuser[2:0];
      in_sg_r <= in_tuser[3];
      in_a_r  <= in_tdata[W-1:0];
      in_b_r  <= in_tdata[W+31:32];
      for (int i = 0; i <= W; i++) st_r[i] <= st_nxt[i];
      res_r   <= res_nxt;
      sts_r   <= sts_nxt;
    end
  end

endmodule

[hdl/cia_checker.sv]
// ----------------------------------------------------------------------------
// cia_checker
// port-level checks for the checked integer alu
// ----------------------------------------------------------------------------
module cia_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // failed results carry zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != cia_pkg::ST_OK |-> out_tdata == 32'd0)
    else $error("nonzero result on failure");

  // status is one of the three codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == cia_pkg::ST_OK || out_tuser == cia_pkg::ST_OVF ||
                    out_tuser == cia_pkg::ST_DIV0))
    else $error("bad status code");

  // a held result blocks new input
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken during output stall");

  // pipeline comes up empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind checked_integer_alu cia_checker u_cia_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[dv/checked_integer_alu_checker.sv]
// ----------------------------------------------------------------------------
// checked_integer_alu_checker
// watches both streams, predicts each result and compares it field by field
// ----------------------------------------------------------------------------
module checked_integer_alu_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] operand_a, [63:32] operand_b
  input  logic [3:0]  in_tuser,   // [2:0] req_type, [3] is_signed
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] result_value
  input  logic [1:0]  out_tuser,  // [1:0] status
  output int          fail_count,
  output int          pending,
  output int          result_count
);

  localparam int EXP_DEPTH = 64;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  st;
  } alu_result_t;

  // ring of expected results, far deeper than the pipeline
  alu_result_t exp_mem [0:EXP_DEPTH-1];
  int          wr_idx;
  int          rd_idx;

  // exact arithmetic in wide signed integers
  function automatic alu_result_t alu_predict(logic [2:0] op, logic sg,
                                              logic [31:0] a, logic [31:0] b);
    alu_result_t r;
    logic signed [66:0] xa;
    logic signed [66:0] xb;
    logic signed [66:0] t;
    logic signed [66:0] lo_lim;
    logic signed [66:0] hi_lim;
    xa = sg ? 67'(signed'(a)) : 67'(a);
    xb = sg ? 67'(signed'(b)) : 67'(b);
    lo_lim = sg ? -67'sh80000000 : 67'sd0;
    hi_lim = sg ? 67'sh7fffffff : 67'shffffffff;
    r.st = cia_pkg::ST_OK;
    t = 0;
    case (op)
      cia_pkg::OP_ADD: t = xa + xb;
      cia_pkg::OP_SUB: t = xa - xb;
      cia_pkg::OP_MUL: t = xa * xb;
      cia_pkg::OP_DIV: if (b == 0) r.st = cia_pkg::ST_DIV0; else t = xa / xb;
      cia_pkg::OP_REM: if (b == 0) r.st = cia_pkg::ST_DIV0; else t = xa % xb;
      default: r.st = cia_pkg::ST_OVF;
    endcase
    if (r.st == cia_pkg::ST_OK && (t < lo_lim || t > hi_lim)) r.st = cia_pkg::ST_OVF;
    r.value = (r.st == cia_pkg::ST_OK) ? t[31:0] : 32'd0;
    return r;
  endfunction

  always @(posedge clk) begin
    alu_result_t exp_r;
    int          level;
    if (!rst_n) begin
      fail_count   <= 0;
      result_count <= 0;
      pending      <= 0;
      wr_idx       <= 0;
      rd_idx       <= 0;
    end else begin
      level = pending;
      if (in_tvalid && in_tready) begin
        if (pending >= EXP_DEPTH) begin
          $error("expected result ring overflow");
          fail_count <= fail_count + 1;
        end
        exp_mem[wr_idx] <= alu_predict(in_tuser[2:0], in_tuser[3],
                                       in_tdata[31:0], in_tdata[63:32]);
        wr_idx <= (wr_idx + 1) % EXP_DEPTH;
        level  = level + 1;
      end
      if (out_tvalid && out_tready) begin
        result_count <= result_count + 1;
        if (pending == 0) begin
          $error("result transfer with nothing expected: %h/%0d", out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          exp_r  = exp_mem[rd_idx];
          rd_idx <= (rd_idx + 1) % EXP_DEPTH;
          level  = level - 1;
          if (out_tdata !== exp_r.value || out_tuser !== exp_r.st) begin
            if (out_tdata !== exp_r.value)
              $error("result_value expected %h actual %h", exp_r.value, out_tdata);
            if (out_tuser !== exp_r.st)
              $error("status expected %0d actual %0d", exp_r.st, out_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= level;
    end
  end

endmodule

[dv/checked_integer_alu_tb.sv]
// ----------------------------------------------------------------------------
// checked_integer_alu_tb
// directed corner requests then random ones, with random stalls on both sides
// ----------------------------------------------------------------------------
module checked_integer_alu_tb;

  localparam int N_RANDOM  = 1530;
  localparam int MAX_CYCLES = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // [31:0] operand_a, [63:32] operand_b
  logic [3:0]  in_tuser = '0;   // [2:0] req_type, [3] is_signed
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [31:0] result_value
  logic [1:0]  out_tuser;       // [1:0] status
  int          fail_count;
  int          pending;
  int          result_count;
  int          cycle_count = 0;
  int          sent_count = 0;
  bit          quiet_tail = 0;  // no idling in the last part
  bit          long_hold = 0;   // receiver holds off for a long stretch

  always #2 clk = ~clk;

  checked_integer_alu DUT (.*);

  checked_integer_alu_checker u_checker (.*);

  // timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, or one long hold-off
  initial begin
    int hold;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (120) @(negedge clk);
        long_hold = 0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        hold = $urandom_range(1, 7);
        repeat (hold) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // operand pick biased toward the interesting edges
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'h1;
      2: return 32'hffffffff;
      3: return 32'h80000000;
      4: return 32'h7fffffff;
      5: return 32'($urandom_range(0, 15));
      6: return 32'h0 - 32'($urandom_range(0, 15));
      7: return 32'($urandom) >> $urandom_range(0, 31);
      default: return 32'($urandom);
    endcase
  endfunction

  // one request transfer; returns after the handshake
  task automatic send_request(logic [2:0] op, logic sg, logic [31:0] a, logic [31:0] b);
    in_tvalid <= 1'b1;
    in_tuser  <= {sg, op};
    in_tdata  <= {b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int gap;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin
    logic [2:0] op;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners, both modes
    for (int s = 0; s < 2; s++) begin
      send_request(cia_pkg::OP_ADD, s[0], 32'hffffffff, 32'h1);
      send_request(cia_pkg::OP_ADD, s[0], 32'h7fffffff, 32'h1);
      send_request(cia_pkg::OP_SUB, s[0], 32'h0, 32'h1);
      send_request(cia_pkg::OP_SUB, s[0], 32'h80000000, 32'h1);
      send_request(cia_pkg::OP_MUL, s[0], 32'h80000000, 32'h2);
      send_request(cia_pkg::OP_MUL, s[0], 32'h80000000, 32'h1);
      send_request(cia_pkg::OP_MUL, s[0], 32'hffffffff, 32'hffffffff);
      send_request(cia_pkg::OP_DIV, s[0], 32'h80000000, 32'hffffffff);
      send_request(cia_pkg::OP_REM, s[0], 32'h80000000, 32'hffffffff);
      send_request(cia_pkg::OP_DIV, s[0], 32'h5, 32'h0);
      send_request(cia_pkg::OP_REM, s[0], 32'hfffffff9, 32'h2);
    end
    send_request(3'd5, 1'b0, 32'h1, 32'h1);
    send_request(3'd7, 1'b1, 32'h1, 32'h1);

    // pause until every expected result has come
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) long_hold = 1;
      if (i == N_RANDOM - 200) quiet_tail = 1;
      op = ($urandom_range(0, 40) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
      send_request(op, 1'($urandom), pick_operand(), pick_operand());
      sender_gap();
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("covered %0d requests, %0d results: all operations, both modes, stalls",
             sent_count, result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
